// ===== sv/asc_pkg.sv =====
package asc_pkg;

   localparam int AREA_MAX_BITS = 35;
   localparam int RAD_BITS      = 36;
   localparam int ROOT_BITS     = 18;
   localparam int REM_BITS      = 20;
   localparam int SIDE_BITS     = 19;
   localparam int DIV_REM_BITS  = 11;
   localparam int SQRT_CELLS    = ROOT_BITS;
   localparam int DIV_CELLS     = SIDE_BITS;
   localparam int LATENCY       = SQRT_CELLS + DIV_CELLS + 6;
   localparam logic [31:0] OUT_W_MAX = 32'h007F_FFFF;
   localparam logic [31:0] OUT_H_MAX = 32'h0003_FFFF;

   typedef struct packed {
      logic [10:0] unit_width;
      logic [10:0] unit_height;
      logic [12:0] unit_count;
      logic        power_of_two;
      logic        square;
   } req_type;

   typedef struct packed {
      logic [22:0] out_width;
      logic [17:0] out_height;
      logic        area_overflow;
   } rsp_type;

   typedef struct packed {
      logic [10:0] w;
      logic [10:0] h;
      logic [12:0] n;
      logic        p2;
      logic        sq;
      logic        ovf;
   } work_type;

   typedef struct packed {
      logic                  valid;
      work_type              work;
      logic [RAD_BITS-1:0]   rad;
      logic [ROOT_BITS-1:0]  root;
      logic [REM_BITS-1:0]   rem;
   } sqrt_type;

   typedef struct packed {
      logic                    valid;
      work_type                work;
      logic [SIDE_BITS-1:0]    s;
      logic [SIDE_BITS-1:0]    dvd;
      logic [DIV_REM_BITS-1:0] rx;
      logic [DIV_REM_BITS-1:0] ry;
      logic [SIDE_BITS-1:0]    qx;
      logic [SIDE_BITS-1:0]    qy;
   } div_type;

   function automatic logic [31:0] pow2_up(input logic [31:0] v);
      logic [31:0] x;
      begin
         x = v - 32'd1;
         x = x | (x >> 1);
         x = x | (x >> 2);
         x = x | (x >> 4);
         x = x | (x >> 8);
         x = x | (x >> 16);
         pow2_up = (v == 32'd0) ? 32'd1 : x + 32'd1;
      end
   endfunction

endpackage

// ===== sv/atlas_size_calculator.sv =====
// channel   ports                      direction  note
// request   start, busy, req_data      in         taken when start && !busy
// response  rsp_valid, rsp_data        out        one-cycle strobe per request
//
// From request to response the pipeline holds 18 square-root cells,
// 19 divider cells and six multiply/select stages.
// One request per cycle; busy is always low.
// Synchronous reset clears every stage's valid bit; requests in flight are dropped.
// The receiver cannot stall, so no response buffering exists.
module atlas_size_calculator #(
   parameter int AREA_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  asc_pkg::req_type req_data,
   output logic             rsp_valid,
   output asc_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic               valid;
      asc_pkg::work_type  work;
      logic [21:0]        wh;
   } s1_type;

   typedef struct packed {
      logic                    valid;
      asc_pkg::work_type       work;
      logic [asc_pkg::SIDE_BITS-1:0] s;
      logic [37:0]             fit;
      logic [30:0]             a;
      logic [30:0]             b;
      logic [30:0]             c;
      logic [23:0]             wn;
   } s4_type;

   logic              s0_valid_ff;
   asc_pkg::work_type s0_work_ff, s0_work_in;
   s1_type            s1_ff, s1_in;
   logic              s2_valid_ff;
   asc_pkg::work_type s2_work_ff, s2_work_in;
   logic [asc_pkg::AREA_MAX_BITS-1:0] s2_area_ff, s2_area_in;
   logic              s2_ovf_in;
   asc_pkg::sqrt_type sq_chain [asc_pkg::SQRT_CELLS+1];
   asc_pkg::div_type  dv_chain [asc_pkg::DIV_CELLS+1];
   asc_pkg::div_type  s3_ff, s3_in;
   s4_type            s4_ff, s4_in;
   logic              rsp_valid_ff;
   asc_pkg::rsp_type  rsp_ff, rsp_in;
   logic [asc_pkg::SIDE_BITS-1:0] root_full;
   logic [31:0]       rw, rh, pa;

   assign busy = 1'b0;

   always_comb begin
      s0_work_in.w   = (req_data.unit_width  == 11'd0) ? 11'd1 : req_data.unit_width;
      s0_work_in.h   = (req_data.unit_height == 11'd0) ? 11'd1 : req_data.unit_height;
      s0_work_in.n   = (req_data.unit_count  == 13'd0) ? 13'd1 : req_data.unit_count;
      s0_work_in.p2  = req_data.power_of_two;
      s0_work_in.sq  = req_data.square;
      s0_work_in.ovf = 1'b0;
   end

   always_ff @(posedge clock) begin
      s0_work_ff <= s0_work_in;
      s0_valid_ff <= reset ? 1'b0 : (start && !busy);
   end

   always_comb begin
      s1_in.valid = s0_valid_ff & ~reset;
      s1_in.work  = s0_work_ff;
      s1_in.wh    = 22'(s0_work_ff.w) * 22'(s0_work_ff.h);
   end

   always_comb begin
      s2_area_in = asc_pkg::AREA_MAX_BITS'(s1_ff.wh) * asc_pkg::AREA_MAX_BITS'(s1_ff.work.n);
      s2_ovf_in = 1'b0;
      for (int i = 0; i < asc_pkg::AREA_MAX_BITS; i++) begin
         if (i >= AREA_BITS) begin
            s2_ovf_in = s2_ovf_in | s2_area_in[i];
         end
      end
      s2_work_in = s1_ff.work;
      s2_work_in.ovf = s2_ovf_in;
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_work_ff <= s2_work_in;
      s2_area_ff <= s2_area_in;
      s2_valid_ff <= reset ? 1'b0 : s1_ff.valid;
   end

   assign sq_chain[0] = {s2_valid_ff, s2_work_ff, 1'b0, s2_area_ff,
                         {asc_pkg::ROOT_BITS{1'b0}}, {asc_pkg::REM_BITS{1'b0}}};

   for (genvar g = 0; g < asc_pkg::SQRT_CELLS; g++) begin : g_sqrt
      asc_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (sq_chain[g]),
         .cell_out (sq_chain[g+1])
      );
   end

   always_comb begin
      root_full = asc_pkg::SIDE_BITS'(sq_chain[asc_pkg::SQRT_CELLS].root)
                + asc_pkg::SIDE_BITS'(sq_chain[asc_pkg::SQRT_CELLS].rem != '0);
      s3_in.valid = sq_chain[asc_pkg::SQRT_CELLS].valid & ~reset;
      s3_in.work  = sq_chain[asc_pkg::SQRT_CELLS].work;
      s3_in.s     = sq_chain[asc_pkg::SQRT_CELLS].work.p2
                  ? asc_pkg::SIDE_BITS'(asc_pkg::pow2_up(32'(root_full))) : root_full;
      s3_in.dvd   = s3_in.s;
      s3_in.rx    = '0;
      s3_in.ry    = '0;
      s3_in.qx    = '0;
      s3_in.qy    = '0;
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
   end

   assign dv_chain[0] = s3_ff;

   for (genvar g = 0; g < asc_pkg::DIV_CELLS; g++) begin : g_div
      asc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (dv_chain[g]),
         .cell_out (dv_chain[g+1])
      );
   end

   always_comb begin
      s4_in.valid = dv_chain[asc_pkg::DIV_CELLS].valid & ~reset;
      s4_in.work  = dv_chain[asc_pkg::DIV_CELLS].work;
      s4_in.s     = dv_chain[asc_pkg::DIV_CELLS].s;
      s4_in.fit   = 38'(dv_chain[asc_pkg::DIV_CELLS].qx) * 38'(dv_chain[asc_pkg::DIV_CELLS].qy);
      s4_in.a     = (31'(dv_chain[asc_pkg::DIV_CELLS].qx) + 31'd1)
                  * 31'(dv_chain[asc_pkg::DIV_CELLS].work.w);
      s4_in.b     = (31'(dv_chain[asc_pkg::DIV_CELLS].qy) + 31'd1)
                  * 31'(dv_chain[asc_pkg::DIV_CELLS].work.h);
      s4_in.c     = 31'(dv_chain[asc_pkg::DIV_CELLS].qx)
                  * 31'(dv_chain[asc_pkg::DIV_CELLS].work.w);
      s4_in.wn    = 24'(dv_chain[asc_pkg::DIV_CELLS].work.w)
                  * 24'(dv_chain[asc_pkg::DIV_CELLS].work.n);
   end

   always_ff @(posedge clock) begin
      s4_ff <= s4_in;
   end

   always_comb begin
      pa = asc_pkg::pow2_up(32'(s4_ff.a));
      rw = 32'(s4_ff.s);
      rh = 32'(s4_ff.s);
      if (s4_ff.work.ovf) begin
         rw = '0;
         rh = '0;
      end else if (!s4_ff.work.p2 && !s4_ff.work.sq) begin
         rw = 32'(s4_ff.wn);
         rh = 32'(s4_ff.work.h);
      end else if (!s4_ff.work.p2) begin
         if (s4_ff.fit < 38'(s4_ff.work.n)) begin
            rw = (s4_ff.a < s4_ff.b) ? 32'(s4_ff.a) : 32'(s4_ff.b);
         end else begin
            rw = 32'(s4_ff.c);
         end
         rh = rw;
      end else if (s4_ff.work.sq) begin
         if (s4_ff.fit < 38'(s4_ff.work.n)) begin
            rw = pa;
         end
         rh = rw;
      end else begin
         if (s4_ff.fit < 38'(s4_ff.work.n)) begin
            rw = pa;
         end else if ((s4_ff.fit >> 1) >= 38'(s4_ff.work.n)) begin
            rh = 32'(s4_ff.s >> 1);
         end
      end
      rsp_in.out_width     = (rw > asc_pkg::OUT_W_MAX) ? 23'h7F_FFFF : rw[22:0];
      rsp_in.out_height    = (rh > asc_pkg::OUT_H_MAX) ? 18'h3_FFFF : rh[17:0];
      rsp_in.area_overflow = s4_ff.work.ovf;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      rsp_valid_ff <= reset ? 1'b0 : s4_ff.valid;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/asc_sqrt_cell.sv =====
module asc_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  asc_pkg::sqrt_type cell_in,
   output asc_pkg::sqrt_type cell_out
);

   asc_pkg::sqrt_type cell_ff, cell_in_c;
   logic [asc_pkg::REM_BITS+1:0] t, trial;
   logic ge;

   always_comb begin
      t = {cell_in.rem, cell_in.rad[asc_pkg::RAD_BITS-1 -: 2]};
      trial = (asc_pkg::REM_BITS+2)'({cell_in.root, 2'b01});
      ge = t >= trial;
      cell_in_c = cell_in;
      cell_in_c.valid = cell_in.valid & ~reset;
      cell_in_c.rem  = ge ? asc_pkg::REM_BITS'(t - trial) : asc_pkg::REM_BITS'(t);
      cell_in_c.root = {cell_in.root[asc_pkg::ROOT_BITS-2:0], ge};
      cell_in_c.rad  = {cell_in.rad[asc_pkg::RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_c;
   end

   assign cell_out = cell_ff;

endmodule

// ===== sv/asc_div_cell.sv =====
module asc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  asc_pkg::div_type cell_in,
   output asc_pkg::div_type cell_out
);

   asc_pkg::div_type cell_ff, cell_in_c;
   logic [asc_pkg::DIV_REM_BITS:0] tx, ty, dx, dy;
   logic gx, gy;

   always_comb begin
      tx = {cell_in.rx, cell_in.dvd[asc_pkg::SIDE_BITS-1]};
      ty = {cell_in.ry, cell_in.dvd[asc_pkg::SIDE_BITS-1]};
      dx = {1'b0, cell_in.work.w};
      dy = {1'b0, cell_in.work.h};
      gx = tx >= dx;
      gy = ty >= dy;
      cell_in_c = cell_in;
      cell_in_c.valid = cell_in.valid & ~reset;
      cell_in_c.rx  = gx ? asc_pkg::DIV_REM_BITS'(tx - dx) : tx[asc_pkg::DIV_REM_BITS-1:0];
      cell_in_c.ry  = gy ? asc_pkg::DIV_REM_BITS'(ty - dy) : ty[asc_pkg::DIV_REM_BITS-1:0];
      cell_in_c.qx  = {cell_in.qx[asc_pkg::SIDE_BITS-2:0], gx};
      cell_in_c.qy  = {cell_in.qy[asc_pkg::SIDE_BITS-2:0], gy};
      cell_in_c.dvd = {cell_in.dvd[asc_pkg::SIDE_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_c;
   end

   assign cell_out = cell_ff;

endmodule

// ===== sv/asc_checker.sv =====
module asc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input asc_pkg::rsp_type rsp_data
);

   logic [5:0] warm_ff, warm_in;
   logic       warm;

   assign warm = warm_ff >= 6'(asc_pkg::LATENCY);
   assign warm_in = warm ? warm_ff : warm_ff + 6'd1;

   always_ff @(posedge clock) begin
      warm_ff <= reset ? 6'd0 : warm_in;
   end

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(start && !busy, asc_pkg::LATENCY)))
      else $error("response does not match request timing");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.area_overflow) |->
         (rsp_data.out_width == '0 && rsp_data.out_height == '0))
      else $error("overflow with nonzero size");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.area_overflow) |->
         (rsp_data.out_width != '0 && rsp_data.out_height != '0))
      else $error("zero size without overflow");

endmodule

bind atlas_size_calculator asc_checker u_asc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int FLUSH_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   asc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   asc_pkg::rsp_type rsp_data;

   asc_pkg::req_type pending_reqs[$];
   asc_pkg::rsp_type expected_sizes[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   bit      stim_done = 1'b0;

   atlas_size_calculator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned root_up(input longint unsigned v);
      longint unsigned r;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) begin
            r = r | (64'd1 << b);
         end
      end
      if (r * r < v) begin
         r = r + 1;
      end
      return r;
   endfunction

   function automatic longint unsigned next_pow2(input longint unsigned v);
      longint unsigned p;
      p = 1;
      while (p < v) begin
         p = p << 1;
      end
      return p;
   endfunction

   function automatic asc_pkg::rsp_type atlas_size(input asc_pkg::req_type r);
      longint unsigned w, h, n, area, s, ux, uy, fit, rw, rh, a, b;
      asc_pkg::rsp_type o;
      w = (r.unit_width == 0) ? 1 : r.unit_width;
      h = (r.unit_height == 0) ? 1 : r.unit_height;
      n = (r.unit_count == 0) ? 1 : r.unit_count;
      area = w * h * n;
      o = '0;
      if ((area >> 32) != 0) begin
         o.area_overflow = 1'b1;
         return o;
      end
      if (!r.power_of_two && !r.square) begin
         rw = w * n;
         rh = h;
      end else begin
         s = root_up(area);
         if (r.power_of_two) begin
            s = next_pow2(s);
         end
         ux = s / w;
         uy = s / h;
         fit = ux * uy;
         if (!r.power_of_two) begin
            if (fit < n) begin
               a = (ux + 1) * w;
               b = (uy + 1) * h;
               rw = (a < b) ? a : b;
            end else begin
               rw = ux * w;
            end
            rh = rw;
         end else if (r.square) begin
            rw = (fit < n) ? next_pow2((ux + 1) * w) : s;
            rh = rw;
         end else begin
            rw = s;
            rh = s;
            if (fit < n) begin
               rw = next_pow2((ux + 1) * w);
            end else if (fit / 2 >= n) begin
               rh = s / 2;
            end
         end
      end
      o.out_width  = (rw > asc_pkg::OUT_W_MAX) ? asc_pkg::OUT_W_MAX[22:0] : rw[22:0];
      o.out_height = (rh > asc_pkg::OUT_H_MAX) ? asc_pkg::OUT_H_MAX[17:0] : rh[17:0];
      return o;
   endfunction

   function automatic asc_pkg::req_type make_req(input int w, input int h, input int n,
                                                 input bit p2, input bit sq);
      asc_pkg::req_type r;
      r.unit_width   = w[10:0];
      r.unit_height  = h[10:0];
      r.unit_count   = n[12:0];
      r.power_of_two = p2;
      r.square       = sq;
      return r;
   endfunction

   // mostly small sizes, some extremes, some full-range (incl. zero and >max)
   function automatic int pick_dim(input int top, input int bits);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, (1 << bits) - 1);
         1: return top;
         2: return 1;
         3, 4: return $urandom_range(1, top);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   initial begin
      int dims[4] = '{0, 1, 1024, 2047};
      int counts[4] = '{0, 1, 4096, 8191};
      for (int m = 0; m < 4; m++) begin
         for (int k = 0; k < 4; k++) begin
            pending_reqs.push_back(make_req(dims[k], dims[3 - k], counts[k], m[1], m[0]));
         end
      end
      for (int m = 0; m < 4; m++) begin
         pending_reqs.push_back(make_req(3, 5, 7, m[1], m[0]));
         pending_reqs.push_back(make_req(1, 1024, 4096, m[1], m[0]));
      end
      for (int i = 0; i < 1750; i++) begin
         pending_reqs.push_back(make_req(pick_dim(1024, 11), pick_dim(1024, 11),
                                         pick_dim(4096, 13), $urandom_range(0, 1),
                                         $urandom_range(0, 1)));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 3) begin
         reset <= 1'b0;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (start && !busy && !reset) begin
         expected_sizes.push_back(atlas_size(req_data));
         void'(pending_reqs.pop_front());
      end
      if (reset || pending_reqs.size() == 0) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else begin
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
         start <= 1'b1;
         req_data <= pending_reqs[0];
      end
   end

   // monitor
   always @(posedge clock) begin
      asc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_sizes.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count = error_count + 1;
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_data.out_width !== want.out_width) begin
               $error("out_width exp %0d got %0d", want.out_width, rsp_data.out_width);
               error_count = error_count + 1;
            end
            if (rsp_data.out_height !== want.out_height) begin
               $error("out_height exp %0d got %0d", want.out_height, rsp_data.out_height);
               error_count = error_count + 1;
            end
            if (rsp_data.area_overflow !== want.area_overflow) begin
               $error("area_overflow exp %0d got %0d", want.area_overflow,
                      rsp_data.area_overflow);
               error_count = error_count + 1;
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_sizes.size() == 0);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_sizes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
